// ===== hdl/tsb_pkg.sv =====
package tsb_pkg;

   localparam int unsigned SLOTS   = 32;
   localparam int unsigned IDX_W   = $clog2(SLOTS);
   localparam int unsigned CNT_W   = IDX_W + 1;
   localparam int unsigned ID_W    = 32;
   localparam int unsigned OP_W    = 2;
   localparam int unsigned CSR_W   = 6;

   localparam logic [CSR_W-1:0] SLOT_COUNT_RESET = CSR_W'(31);

   localparam logic [OP_W-1:0] OP_BIND       = 2'd0;
   localparam logic [OP_W-1:0] OP_UNBIND     = 2'd1;
   localparam logic [OP_W-1:0] OP_UNBIND_ALL = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic [ID_W-1:0] texture_id;
   } tsb_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] slot;
      logic             hit;
   } tsb_rsp_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] slot;
   } tsb_match_type;

endpackage

// ===== hdl/tsb_match.sv =====
module tsb_match (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [tsb_pkg::SLOTS-1:0][tsb_pkg::ID_W-1:0] entry_id,
   input  logic [tsb_pkg::SLOTS-1:0]                entry_valid,
   input  logic [tsb_pkg::ID_W-1:0]                 lookup_id,
   output tsb_pkg::tsb_match_type                   match
);

   logic [tsb_pkg::SLOTS-1:0] hit_vec;

   always_comb begin
      for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
         hit_vec[i] = entry_valid[i] && (entry_id[i] == lookup_id);
      end
   end

   // lowest matching slot wins
   always_comb begin
      match.hit  = |hit_vec;
      match.slot = '0;
      for (int i = tsb_pkg::SLOTS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            match.slot = tsb_pkg::IDX_W'(i);
         end
      end
   end

   // a miss-only insert never leaves two live copies of one id
   assert property (@(posedge clock) disable iff (reset) $onehot0(hit_vec))
      else $error("duplicate live texture id in slot table");

endmodule

// ===== hdl/texture_slot_binder.sv =====
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_stall  tsb_req_type (opcode, texture_id)
// rsp      out  rsp_valid/rsp_stall  tsb_rsp_type (slot, hit)
// csr      in   csr_valid/csr_ready  slot_count, 6 bits
//
// One item per cycle while the response is not stalled; each item is held in
// the request register and then sits in the response register until it is
// taken. The parallel tag compare plus pointer update sets the cycle.
// Reset clears all valid marks, the replacement pointer, and loads slot_count
// with 31; no clearing pass is needed. A stalled response holds the request
// register, which then stalls req.
module texture_slot_binder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tsb_pkg::tsb_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tsb_pkg::tsb_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [tsb_pkg::CSR_W-1:0] csr_data
);

   logic                              req_valid_ff;
   tsb_pkg::tsb_req_type              req_data_ff;
   logic                              rsp_valid_ff;
   tsb_pkg::tsb_rsp_type              rsp_data_ff;
   tsb_pkg::tsb_rsp_type              rsp_data_in;
   logic [tsb_pkg::CSR_W-1:0]         slot_count_ff;
   logic [tsb_pkg::SLOTS-1:0]         valid_ff;
   logic [tsb_pkg::SLOTS-1:0]         valid_in;
   logic [tsb_pkg::IDX_W-1:0]         next_slot_ff;
   logic [tsb_pkg::IDX_W-1:0]         next_slot_in;
   logic [tsb_pkg::SLOTS-1:0][tsb_pkg::ID_W-1:0] id_ff;

   tsb_pkg::tsb_match_type            match;
   logic                              advance;
   logic                              id_write;
   logic [tsb_pkg::CNT_W-1:0]         count;
   logic [tsb_pkg::IDX_W-1:0]         victim;
   logic [tsb_pkg::CNT_W-1:0]         victim_inc;

   tsb_match u_match (
      .clock       (clock),
      .reset       (reset),
      .entry_id    (id_ff),
      .entry_valid (valid_ff),
      .lookup_id   (req_data_ff.texture_id),
      .match       (match)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // clamp slot_count to 1..SLOTS
   always_comb begin
      if (slot_count_ff == '0) begin
         count = tsb_pkg::CNT_W'(1);
      end else if (slot_count_ff > tsb_pkg::CSR_W'(tsb_pkg::SLOTS)) begin
         count = tsb_pkg::CNT_W'(tsb_pkg::SLOTS);
      end else begin
         count = tsb_pkg::CNT_W'(slot_count_ff);
      end
   end

   always_comb begin
      if ({1'b0, next_slot_ff} >= count) begin
         victim = '0;
      end else begin
         victim = next_slot_ff;
      end
      victim_inc = {1'b0, victim} + tsb_pkg::CNT_W'(1);
   end

   always_comb begin
      valid_in     = valid_ff;
      next_slot_in = next_slot_ff;
      rsp_data_in  = '0;
      id_write     = 1'b0;
      case (req_data_ff.opcode)
         tsb_pkg::OP_BIND: begin
            if (match.hit) begin
               rsp_data_in.slot = match.slot;
               rsp_data_in.hit  = 1'b1;
            end else begin
               id_write         = 1'b1;
               valid_in[victim] = 1'b1;
               next_slot_in     = (victim_inc == count) ? '0
                                                        : victim_inc[tsb_pkg::IDX_W-1:0];
               rsp_data_in.slot = victim;
            end
         end
         tsb_pkg::OP_UNBIND: begin
            if (match.hit) begin
               valid_in[match.slot] = 1'b0;
               rsp_data_in.slot     = match.slot;
               rsp_data_in.hit      = 1'b1;
            end
         end
         tsb_pkg::OP_UNBIND_ALL: begin
            valid_in     = '0;
            next_slot_in = '0;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         next_slot_ff  <= '0;
         slot_count_ff <= tsb_pkg::SLOT_COUNT_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            valid_ff     <= valid_in;
            next_slot_ff <= next_slot_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            slot_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (advance && id_write) begin
         id_ff[victim] <= req_data_ff.texture_id;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      advance && req_data_ff.opcode == tsb_pkg::OP_UNBIND_ALL
      |=> valid_ff == '0 && next_slot_ff == '0)
      else $error("unbind all left live slots or pointer");

   assert property (@(posedge clock) disable iff (reset)
      advance && req_data_ff.opcode == tsb_pkg::OP_BIND && !match.hit
      |=> valid_ff[$past(victim)] && rsp_data_ff.slot == $past(victim) && !rsp_data_ff.hit)
      else $error("bind miss did not claim victim slot");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled response lost");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without back pressure");

endmodule

// ===== test/texture_slot_binder_tb.sv =====
`timescale 1ns / 100ps

module texture_slot_binder_tb;

   localparam logic [tsb_pkg::OP_W-1:0] OP_SPARE = 2'd3;
   localparam int unsigned SLOT_CAP = (tsb_pkg::SLOTS < 32) ? tsb_pkg::SLOTS : 32;
   localparam int unsigned ID_POOL = 40;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic                 drain_first;
      tsb_pkg::tsb_req_type cmd;
   } queued_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   tsb_pkg::tsb_req_type          req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   tsb_pkg::tsb_rsp_type          rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [tsb_pkg::CSR_W-1:0]     csr_data = '0;

   queued_cmd_type        pending_cmds[$];
   tsb_pkg::tsb_rsp_type  expected_binds[$];
   int unsigned    accepted_total = 0;
   int unsigned    delivered_total = 0;
   int unsigned    sender_idle_pct = 0;
   int unsigned    receiver_stall_pct = 0;
   int unsigned    error_count = 0;

   // binding table as the testbench sees it
   logic [tsb_pkg::ID_W-1:0]  bound_id [tsb_pkg::SLOTS];
   logic [tsb_pkg::SLOTS-1:0] bound_live;
   logic [tsb_pkg::IDX_W-1:0] rr_ptr;
   logic [tsb_pkg::CSR_W-1:0] slot_limit;

   logic [tsb_pkg::ID_W-1:0]  id_pool [ID_POOL];

   texture_slot_binder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic tsb_pkg::tsb_rsp_type apply_binding(tsb_pkg::tsb_req_type cmd);
      tsb_pkg::tsb_rsp_type res;
      int          found;
      int unsigned count;
      int unsigned victim;
      res = '0;
      found = -1;
      for (int i = 0; i < SLOT_CAP; i++) begin
         if (found < 0 && bound_live[i] && bound_id[i] == cmd.texture_id)
            found = i;
      end
      case (cmd.opcode)
         tsb_pkg::OP_BIND: begin
            if (found >= 0) begin
               res.slot = tsb_pkg::IDX_W'(found);
               res.hit = 1'b1;
            end else begin
               count = 32'(slot_limit);
               if (count < 1)
                  count = 1;
               if (count > SLOT_CAP)
                  count = SLOT_CAP;
               victim = 32'(rr_ptr);
               // pointer left past a lowered count restarts at slot zero
               if (victim >= count)
                  victim = 0;
               bound_id[victim] = cmd.texture_id;
               bound_live[victim] = 1'b1;
               rr_ptr = tsb_pkg::IDX_W'((victim + 1) % count);
               res.slot = tsb_pkg::IDX_W'(victim);
            end
         end
         tsb_pkg::OP_UNBIND: begin
            if (found >= 0) begin
               bound_live[found] = 1'b0;
               res.slot = tsb_pkg::IDX_W'(found);
               res.hit = 1'b1;
            end
         end
         tsb_pkg::OP_UNBIND_ALL: begin
            bound_live = '0;
            rr_ptr = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : drive_requests
      logic taken;
      logic go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken) begin
            expected_binds = {expected_binds, apply_binding(req_data)};
            accepted_total <= accepted_total + 1;
         end
         if (taken || !req_valid) begin
            go = pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct;
            // hold this transfer back until every outstanding result is in
            if (go && pending_cmds[0].drain_first &&
                (taken || accepted_total != delivered_total))
               go = 1'b0;
            if (go) begin
               req_data <= pending_cmds[0].cmd;
               pending_cmds.delete(0);
            end
            req_valid <= go;
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= $urandom_range(99) < receiver_stall_pct;
   end

   always @(posedge clock) begin : check_responses
      tsb_pkg::tsb_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         delivered_total <= delivered_total + 1;
         if (expected_binds.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected result slot=%0d hit=%0b", $realtime,
                        rsp_data.slot, rsp_data.hit);
         end else begin
            want = expected_binds.pop_front();
            if (rsp_data.slot !== want.slot) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: slot mismatch expected %0d actual %0d", $realtime,
                           want.slot, rsp_data.slot);
            end
            if (rsp_data.hit !== want.hit) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: hit mismatch expected %0b actual %0b", $realtime,
                           want.hit, rsp_data.hit);
            end
         end
      end
   end

   task automatic queue_cmd(logic [tsb_pkg::OP_W-1:0] op, logic [tsb_pkg::ID_W-1:0] id,
                            logic drain_first = 1'b0);
      queued_cmd_type item;
      item.drain_first = drain_first;
      item.cmd.opcode = op;
      item.cmd.texture_id = id;
      pending_cmds = {pending_cmds, item};
   endtask

   task automatic settle();
      do
         @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid || accepted_total != delivered_total);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_slot_count(logic [tsb_pkg::CSR_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      slot_limit = value;
   endtask

   task automatic queue_random(int unsigned n);
      int unsigned               roll;
      logic [tsb_pkg::ID_W-1:0]  id;
      logic [tsb_pkg::OP_W-1:0]  op;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0)
            id = $urandom();
         else
            id = id_pool[$urandom_range(ID_POOL - 1)];
         roll = $urandom_range(99);
         if (roll < 62)
            op = tsb_pkg::OP_BIND;
         else if (roll < 92)
            op = tsb_pkg::OP_UNBIND;
         else if (roll < 96)
            op = tsb_pkg::OP_UNBIND_ALL;
         else
            op = OP_SPARE;
         queue_cmd(op, id, $urandom_range(99) == 0);
      end
   endtask

   task automatic run_phase(logic [tsb_pkg::CSR_W-1:0] count, int unsigned idle_pct,
                            int unsigned stall_pct, int unsigned n);
      write_slot_count(count);
      sender_idle_pct <= idle_pct;
      receiver_stall_pct <= stall_pct;
      queue_random(n);
   endtask

   initial begin
      bound_live = '0;
      rr_ptr = '0;
      slot_limit = tsb_pkg::SLOT_COUNT_RESET;
      for (int i = 0; i < ID_POOL; i++)
         id_pool[i] = $urandom();
      id_pool[0] = '0;
      id_pool[1] = '1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset count, hits, misses, absent unbind, spare opcode
      queue_cmd(tsb_pkg::OP_BIND, 32'h0000_0000);
      queue_cmd(tsb_pkg::OP_BIND, 32'hFFFF_FFFF);
      queue_cmd(tsb_pkg::OP_BIND, 32'h0000_0000);
      queue_cmd(tsb_pkg::OP_UNBIND, 32'hFFFF_FFFF);
      queue_cmd(tsb_pkg::OP_UNBIND, 32'hFFFF_FFFF);
      queue_cmd(OP_SPARE, 32'h0000_0000);
      queue_cmd(tsb_pkg::OP_BIND, 32'h0000_0000, 1'b1);
      queue_cmd(tsb_pkg::OP_UNBIND_ALL, 32'hA5A5_5A5A);
      queue_cmd(tsb_pkg::OP_BIND, 32'h0000_0000);
      for (int i = 1; i <= 5; i++)
         queue_cmd(tsb_pkg::OP_BIND, tsb_pkg::ID_W'(i));

      // lower the count below the pointer; old entries above it must still hit
      write_slot_count(6'd3);
      queue_cmd(tsb_pkg::OP_BIND, 32'd100);
      queue_cmd(tsb_pkg::OP_BIND, 32'd5);
      queue_cmd(tsb_pkg::OP_UNBIND, 32'd4);
      queue_cmd(tsb_pkg::OP_BIND, 32'd101);
      queue_cmd(tsb_pkg::OP_BIND, 32'd102);
      queue_cmd(tsb_pkg::OP_BIND, 32'd103);
      queue_cmd(tsb_pkg::OP_BIND, 32'd100);

      // zero acts as one slot
      write_slot_count(6'd0);
      queue_cmd(tsb_pkg::OP_BIND, 32'd200);
      queue_cmd(tsb_pkg::OP_BIND, 32'd201);

      // values above the cap act as the cap
      write_slot_count(6'd63);
      queue_cmd(tsb_pkg::OP_BIND, 32'h5555_AAAA);
      queue_cmd(tsb_pkg::OP_BIND, 32'hAAAA_5555);

      run_phase(6'd32, 0, 0, 120);
      run_phase(6'd1, 55, 0, 110);
      run_phase(6'd5, 0, 55, 110);
      run_phase(6'd63, 37, 37, 120);
      run_phase(6'd0, 0, 0, 100);
      run_phase(tsb_pkg::CSR_W'($urandom_range(1, 32)), 55, 55, 60);
      run_phase(6'd33, 37, 37, 80);

      settle();
      repeat (8) @(posedge clock);
      if (expected_binds.size() != 0) begin
         error_count++;
         $display("%0d expected results never arrived", expected_binds.size());
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tsb_pkg.sv
hdl/tsb_match.sv
hdl/texture_slot_binder.sv
test/texture_slot_binder_tb.sv
